// ----- rtl/csi_pkg.sv -----
// ----------------------------------------------------------------------------
// csi_pkg
// Shared constants, codes and types for the colour scale interpolator.
// ----------------------------------------------------------------------------
package csi_pkg;

	// table size and derived widths
	localparam int MAX_POINTS = 16;
	localparam int AW         = $clog2(MAX_POINTS);
	localparam int CW         = $clog2(MAX_POINTS + 1);

	// stream word widths
	localparam int IN_W  = 80;
	localparam int OUT_W = 48;

	// command codes
	localparam logic [2:0] CMD_ADD    = 3'd0;
	localparam logic [2:0] CMD_SET    = 3'd1;
	localparam logic [2:0] CMD_REMOVE = 3'd2;
	localparam logic [2:0] CMD_LOOKUP = 3'd3;
	localparam logic [2:0] CMD_CLEAR  = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_POS = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// colour of an empty table (rgba)
	localparam logic [31:0] EMPTY_COLOUR = 32'h0000_00FF;

	// sequencer states
	typedef enum logic [16:0] {
		S_IDLE     = 17'h00001,
		S_ADD_RD   = 17'h00002,
		S_ADD_CMP  = 17'h00004,
		S_WR       = 17'h00008,
		S_SET_RD   = 17'h00010,
		S_SET_CHK  = 17'h00020,
		S_SET_UP   = 17'h00040,
		S_SET_DNR  = 17'h00080,
		S_SET_DN   = 17'h00100,
		S_REM_RD   = 17'h00200,
		S_REM_MV   = 17'h00400,
		S_LK_RD    = 17'h00800,
		S_LK_FIRST = 17'h01000,
		S_LK_WALK  = 17'h02000,
		S_MUL      = 17'h04000,
		S_DIV      = 17'h08000,
		S_DONE     = 17'h10000
	} state_t;

endpackage

// ----- rtl/colour_scale_interpolator.sv -----
// ----------------------------------------------------------------------------
// colour_scale_interpolator
// Sorted breakpoint table (Q16.16 value, rgba colour) held in two RAMs,
// edited by add/set/remove/clear commands and read by piecewise linear lookup.
//
//  channel   | dir | handshake           | word
//  ----------+-----+---------------------+--------------------------------
//  s_*       | in  | s_tvalid / s_tready | one command
//  m_*       | out | m_tvalid / m_tready | one result per command
//  cfg_*     | in  | cfg_valid/cfg_ready | interpolate bit
//
// One command at a time. Add, set and remove walk the table one entry per
// cycle through the RAM read port; lookup walks up to count entries, then one
// shared 8-step divider blends each channel in turn. Clear and errors go
// straight from acceptance to the final state.
// Reset clears the count and sets interpolate; the RAMs are not cleared.
// A waiting result sits in the output register while the next command is
// taken; a stalled output only holds the sequencer in its final state.
// ----------------------------------------------------------------------------
module colour_scale_interpolator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// cmd, value, red_in, green_in, blue_in, alpha_in, position,
	// write_value, write_colour, zero fill
	input  logic [csi_pkg::IN_W-1:0]   s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// red_out, green_out, blue_out, alpha_out, status, placed_at,
	// point_count, zero fill
	output logic [csi_pkg::OUT_W-1:0]  m_tdata,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_data
);

	localparam int AW = csi_pkg::AW;
	localparam int CW = csi_pkg::CW;

	csi_pkg::state_t state_q;

	logic               interp_q;
	logic [CW-1:0]      used_q;
	logic [2:0]         cmd_q;
	logic signed [31:0] v_q;
	logic [31:0]        col_q;
	logic [3:0]         pos_q;
	logic               wv_q;
	logic               wc_q;
	logic [AW-1:0]      j_q;
	logic [AW-1:0]      place_q;

	// lookup datapath
	logic signed [31:0] s_q;
	logic [31:0]        c0_q;
	logic [31:0]        c1_q;
	logic [31:0]        width_q;
	logic [31:0]        off_q;
	logic [1:0]         k_q;
	logic [2:0]         b_q;
	logic [39:0]        rem_q;
	logic [7:0]         quo_q;
	logic               neg_q;

	// result staging and output register
	logic [31:0]            res_col_q;
	logic [1:0]             res_status_q;
	logic [AW-1:0]          res_placed_q;
	logic                   m_tvalid_q;
	logic [csi_pkg::OUT_W-1:0] m_tdata_q;
	logic                   out_load;

	// ram ports
	logic          we_v;
	logic          we_c;
	logic [AW-1:0] waddr;
	logic [31:0]   wval;
	logic [31:0]   wcol;
	logic [AW-1:0] raddr;
	logic [31:0]   rd_val_raw;
	logic [31:0]   rd_col;
	logic signed [31:0] rd_val;

	// input fields
	logic [2:0]         in_cmd;
	logic signed [31:0] in_value;
	logic [31:0]        in_col;
	logic [3:0]         in_pos;
	logic               accept;
	logic               full;
	logic               pos_bad;
	logic               pos_last;
	logic               j_last;

	// divider step
	logic [7:0]  s_ch;
	logic [7:0]  e_ch;
	logic [7:0]  mag;
	logic [39:0] dsh;
	logic        ge;
	logic [7:0]  quo_n;
	logic [7:0]  ch_out;

	assign in_cmd   = s_tdata[2:0];
	assign in_value = s_tdata[34:3];
	assign in_col   = {s_tdata[42:35], s_tdata[50:43], s_tdata[58:51], s_tdata[66:59]};
	assign in_pos   = s_tdata[70:67];

	assign s_tready  = (state_q == csi_pkg::S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign out_load  = (state_q == csi_pkg::S_DONE) && (!m_tvalid_q || m_tready);

	assign full     = (used_q == CW'(csi_pkg::MAX_POINTS));
	assign pos_bad  = (32'(in_pos) >= 32'(used_q));
	assign pos_last = (32'(in_pos) + 32'd1 == 32'(used_q));
	assign j_last   = (CW'(j_q) + CW'(1) == used_q);
	assign rd_val   = rd_val_raw;

	// breakpoint storage
	csi_ram #(.WIDTH(32), .DEPTH(csi_pkg::MAX_POINTS)) u_values (
		.clk   (clk),
		.we    (we_v),
		.waddr (waddr),
		.wdata (wval),
		.raddr (raddr),
		.rdata (rd_val_raw)
	);

	csi_ram #(.WIDTH(32), .DEPTH(csi_pkg::MAX_POINTS)) u_colours (
		.clk   (clk),
		.we    (we_c),
		.waddr (waddr),
		.wdata (wcol),
		.raddr (raddr),
		.rdata (rd_col)
	);

	// ram address and write control
	always_comb begin
		we_v  = 1'b0;
		we_c  = 1'b0;
		waddr = j_q + AW'(1);
		wval  = rd_val_raw;
		wcol  = rd_col;
		raddr = j_q;
		unique case (state_q)
			csi_pkg::S_ADD_CMP: begin
				raddr = j_q - AW'(1);
				if (rd_val > v_q) begin
					we_v = 1'b1;
					we_c = 1'b1;
				end
			end
			csi_pkg::S_SET_RD: begin
				raddr = AW'(pos_q);
			end
			csi_pkg::S_SET_CHK: begin
				raddr = AW'(pos_q) - AW'(1);
			end
			csi_pkg::S_SET_UP: begin
				raddr = j_q - AW'(1);
				if (rd_val > v_q) begin
					we_v = 1'b1;
					we_c = 1'b1;
				end
			end
			csi_pkg::S_SET_DNR: begin
				raddr = AW'(pos_q) + AW'(1);
			end
			csi_pkg::S_SET_DN: begin
				raddr = j_q + AW'(1);
				waddr = j_q - AW'(1);
				if (rd_val < v_q) begin
					we_v = 1'b1;
					we_c = 1'b1;
				end
			end
			csi_pkg::S_REM_MV: begin
				raddr = j_q + AW'(1);
				waddr = j_q - AW'(1);
				we_v  = 1'b1;
				we_c  = 1'b1;
			end
			csi_pkg::S_WR: begin
				waddr = place_q;
				wval  = v_q;
				wcol  = col_q;
				we_v  = 1'b1;
				we_c  = 1'b1;
			end
			csi_pkg::S_LK_RD: begin
				raddr = '0;
			end
			csi_pkg::S_LK_FIRST: begin
				raddr = AW'(1);
			end
			csi_pkg::S_LK_WALK: begin
				raddr = j_q + AW'(1);
			end
			default: begin
			end
		endcase
	end

	// blend step: channel select, magnitude and one restoring divide bit
	always_comb begin
		s_ch   = c0_q[8*(3-k_q) +: 8];
		e_ch   = c1_q[8*(3-k_q) +: 8];
		mag    = (e_ch < s_ch) ? (s_ch - e_ch) : (e_ch - s_ch);
		dsh    = 40'(width_q) << b_q;
		ge     = (width_q != 32'd0) && (rem_q >= dsh);
		quo_n  = quo_q | (ge ? (8'd1 << b_q) : 8'd0);
		ch_out = neg_q ? (s_ch - quo_n) : (s_ch + quo_n);
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interp_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			interp_q <= cfg_data;
		end
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= csi_pkg::S_IDLE;
			used_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				csi_pkg::S_IDLE: begin
					if (accept) begin
						cmd_q        <= in_cmd;
						v_q          <= in_value;
						col_q        <= in_col;
						pos_q        <= in_pos;
						wv_q         <= s_tdata[71];
						wc_q         <= s_tdata[72];
						res_placed_q <= '0;
						case (in_cmd)
							csi_pkg::CMD_ADD: begin
								res_col_q    <= '0;
								res_status_q <= full ? csi_pkg::ST_FULL : csi_pkg::ST_OK;
								if (full) begin
									state_q <= csi_pkg::S_DONE;
								end else if (used_q == '0) begin
									place_q <= '0;
									state_q <= csi_pkg::S_WR;
								end else begin
									j_q     <= AW'(used_q - CW'(1));
									state_q <= csi_pkg::S_ADD_RD;
								end
							end
							csi_pkg::CMD_SET: begin
								res_col_q    <= '0;
								res_status_q <= pos_bad ? csi_pkg::ST_BAD_POS : csi_pkg::ST_OK;
								state_q      <= pos_bad ? csi_pkg::S_DONE : csi_pkg::S_SET_RD;
							end
							csi_pkg::CMD_REMOVE: begin
								res_col_q    <= '0;
								res_status_q <= pos_bad ? csi_pkg::ST_BAD_POS : csi_pkg::ST_OK;
								if (pos_bad) begin
									state_q <= csi_pkg::S_DONE;
								end else if (pos_last) begin
									used_q  <= used_q - CW'(1);
									state_q <= csi_pkg::S_DONE;
								end else begin
									j_q     <= AW'(in_pos) + AW'(1);
									state_q <= csi_pkg::S_REM_RD;
								end
							end
							csi_pkg::CMD_LOOKUP: begin
								res_status_q <= csi_pkg::ST_OK;
								if (used_q == '0) begin
									res_col_q <= csi_pkg::EMPTY_COLOUR;
									state_q   <= csi_pkg::S_DONE;
								end else begin
									res_col_q <= '0;
									state_q   <= csi_pkg::S_LK_RD;
								end
							end
							csi_pkg::CMD_CLEAR: begin
								res_col_q    <= '0;
								res_status_q <= csi_pkg::ST_OK;
								used_q       <= '0;
								state_q      <= csi_pkg::S_DONE;
							end
							default: begin
								res_col_q    <= '0;
								res_status_q <= csi_pkg::ST_OK;
								state_q      <= csi_pkg::S_DONE;
							end
						endcase
					end
				end

				// add: shift greater entries up until the slot is found
				csi_pkg::S_ADD_RD: begin
					state_q <= csi_pkg::S_ADD_CMP;
				end
				csi_pkg::S_ADD_CMP: begin
					if (rd_val > v_q) begin
						if (j_q == '0) begin
							place_q <= '0;
							state_q <= csi_pkg::S_WR;
						end else begin
							j_q <= j_q - AW'(1);
						end
					end else begin
						place_q <= j_q + AW'(1);
						state_q <= csi_pkg::S_WR;
					end
				end

				// final write of the new or edited point
				csi_pkg::S_WR: begin
					if (cmd_q == csi_pkg::CMD_ADD) begin
						used_q <= used_q + CW'(1);
					end
					res_placed_q <= place_q;
					state_q      <= csi_pkg::S_DONE;
				end

				// set: fetch the point, then write it in place or move it up or down
				csi_pkg::S_SET_RD: begin
					state_q <= csi_pkg::S_SET_CHK;
				end
				csi_pkg::S_SET_CHK: begin
					if (!wc_q) begin
						col_q <= rd_col;
					end
					if (!wv_q) begin
						v_q     <= rd_val;
						place_q <= AW'(pos_q);
						state_q <= csi_pkg::S_WR;
					end else if (pos_q == 4'd0) begin
						state_q <= csi_pkg::S_SET_DNR;
					end else begin
						j_q     <= AW'(pos_q) - AW'(1);
						state_q <= csi_pkg::S_SET_UP;
					end
				end
				csi_pkg::S_SET_UP: begin
					if (rd_val > v_q) begin
						if (j_q == '0) begin
							place_q <= '0;
							state_q <= csi_pkg::S_WR;
						end else begin
							j_q <= j_q - AW'(1);
						end
					end else if (j_q + AW'(1) == AW'(pos_q)) begin
						state_q <= csi_pkg::S_SET_DNR;
					end else begin
						place_q <= j_q + AW'(1);
						state_q <= csi_pkg::S_WR;
					end
				end
				csi_pkg::S_SET_DNR: begin
					if (32'(pos_q) + 32'd1 >= 32'(used_q)) begin
						place_q <= AW'(pos_q);
						state_q <= csi_pkg::S_WR;
					end else begin
						j_q     <= AW'(pos_q) + AW'(1);
						state_q <= csi_pkg::S_SET_DN;
					end
				end
				csi_pkg::S_SET_DN: begin
					if (rd_val < v_q) begin
						if (j_last) begin
							place_q <= j_q;
							state_q <= csi_pkg::S_WR;
						end else begin
							j_q <= j_q + AW'(1);
						end
					end else begin
						place_q <= j_q - AW'(1);
						state_q <= csi_pkg::S_WR;
					end
				end

				// remove: shift later entries down by one
				csi_pkg::S_REM_RD: begin
					state_q <= csi_pkg::S_REM_MV;
				end
				csi_pkg::S_REM_MV: begin
					if (j_last) begin
						used_q  <= used_q - CW'(1);
						state_q <= csi_pkg::S_DONE;
					end else begin
						j_q <= j_q + AW'(1);
					end
				end

				// lookup: find the first segment that holds the value
				csi_pkg::S_LK_RD: begin
					state_q <= csi_pkg::S_LK_FIRST;
				end
				csi_pkg::S_LK_FIRST: begin
					if ((v_q < rd_val) || (used_q == CW'(1))) begin
						res_col_q <= rd_col;
						state_q   <= csi_pkg::S_DONE;
					end else begin
						s_q     <= rd_val;
						c0_q    <= rd_col;
						j_q     <= AW'(1);
						state_q <= csi_pkg::S_LK_WALK;
					end
				end
				csi_pkg::S_LK_WALK: begin
					if (v_q <= rd_val) begin
						c1_q    <= rd_col;
						width_q <= rd_val_raw - s_q;
						off_q   <= interp_q ? (v_q - s_q) : 32'd0;
						k_q     <= 2'd0;
						state_q <= csi_pkg::S_MUL;
					end else if (j_last) begin
						res_col_q <= rd_col;
						state_q   <= csi_pkg::S_DONE;
					end else begin
						s_q  <= rd_val;
						c0_q <= rd_col;
						j_q  <= j_q + AW'(1);
					end
				end

				// blend one channel: product, then eight divide steps
				csi_pkg::S_MUL: begin
					rem_q   <= 40'(mag) * 40'(off_q);
					neg_q   <= (e_ch < s_ch);
					quo_q   <= '0;
					b_q     <= 3'd7;
					state_q <= csi_pkg::S_DIV;
				end
				csi_pkg::S_DIV: begin
					if (ge) begin
						rem_q <= rem_q - dsh;
					end
					quo_q <= quo_n;
					if (b_q == 3'd0) begin
						res_col_q[8*(3-k_q) +: 8] <= ch_out;
						if (k_q == 2'd3) begin
							state_q <= csi_pkg::S_DONE;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= csi_pkg::S_MUL;
						end
					end else begin
						b_q <= b_q - 3'd1;
					end
				end

				// hand the result to the output register
				csi_pkg::S_DONE: begin
					if (out_load) begin
						m_tdata_q  <= {5'd0, 5'(used_q), 4'(res_placed_q), res_status_q,
						               res_col_q[7:0], res_col_q[15:8],
						               res_col_q[23:16], res_col_q[31:24]};
						state_q    <= csi_pkg::S_IDLE;
					end
				end

				default: begin
					state_q <= csi_pkg::S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/csi_ram.sv -----
// ----------------------------------------------------------------------------
// csi_ram
// Generic simple dual port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module csi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- tb/colour_scale_interpolator_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// colour_scale_interpolator_test
// Drives command words into the breakpoint table and checks every result word
// against a behavioral table model kept inside this bench.
// ----------------------------------------------------------------------------
module colour_scale_interpolator_test;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int RANDOM_ITEMS = 1900;

	// one command word, with the fields that pack_command places in s_tdata
	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] value;
		logic [31:0] rgba;
		logic [3:0]  position;
		logic        write_value;
		logic        write_colour;
	} command_t;

	// one result word
	typedef struct packed {
		logic [31:0] rgba;
		logic [1:0]  status;
		logic [3:0]  placed_at;
		logic [4:0]  point_count;
	} result_t;

	// directed row: command, whether a typed result applies, the typed result
	typedef struct {
		command_t op;
		bit       typed;
		result_t  want;
	} directed_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [csi_pkg::IN_W-1:0]  s_tdata;
	logic                      m_tvalid;
	logic                      m_tready;
	logic [csi_pkg::OUT_W-1:0] m_tdata;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic                      cfg_data;

	// table model state
	logic signed [31:0] model_values[csi_pkg::MAX_POINTS];
	logic [31:0]        model_colours[csi_pkg::MAX_POINTS];
	int                 model_count;
	bit                 model_interp;

	result_t pending_results[$];
	int      mismatches;
	int      cycles;
	bit      hold_receiver;

	colour_scale_interpolator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [csi_pkg::IN_W-1:0] pack_command(command_t c);
		logic [csi_pkg::IN_W-1:0] w;
		w = '0;
		w[2:0]   = c.cmd;
		w[34:3]  = c.value;
		w[42:35] = c.rgba[31:24];
		w[50:43] = c.rgba[23:16];
		w[58:51] = c.rgba[15:8];
		w[66:59] = c.rgba[7:0];
		w[70:67] = c.position;
		w[71]    = c.write_value;
		w[72]    = c.write_colour;
		return w;
	endfunction

	function automatic result_t unpack_result(logic [csi_pkg::OUT_W-1:0] w);
		result_t r;
		r.rgba        = {w[7:0], w[15:8], w[23:16], w[31:24]};
		r.status      = w[33:32];
		r.placed_at   = w[37:34];
		r.point_count = w[42:38];
		return r;
	endfunction

	// per-channel blend across one segment
	function automatic logic [31:0] blend_segment(logic [31:0] c0, logic [31:0] c1,
			longint off, longint width);
		logic [31:0] out;
		longint s, d, r;
		out = '0;
		for (int k = 0; k < 4; k++) begin
			s = c0[31-8*k -: 8];
			d = longint'(c1[31-8*k -: 8]) - s;
			r = s;
			if (width > 0)
				r = s + (d * off) / width;
			out[31-8*k -: 8] = r[7:0];
		end
		return out;
	endfunction

	function automatic logic [31:0] lookup_colour(logic signed [31:0] v);
		longint s, e;
		if (model_count == 0)
			return csi_pkg::EMPTY_COLOUR;
		if (v < model_values[0])
			return model_colours[0];
		for (int i = 0; i + 1 < model_count; i++) begin
			s = model_values[i];
			e = model_values[i+1];
			if (v >= s && v <= e)
				return blend_segment(model_colours[i], model_colours[i+1],
					model_interp ? longint'(v) - s : 64'sd0, e - s);
		end
		return model_colours[model_count-1];
	endfunction

	function automatic void swap_points(int a, int b);
		logic [31:0] tv, tc;
		tv = model_values[a];
		tc = model_colours[a];
		model_values[a] = model_values[b];
		model_colours[a] = model_colours[b];
		model_values[b] = tv;
		model_colours[b] = tc;
	endfunction

	// applies one command to the table model and returns its result
	function automatic result_t apply_command(command_t c);
		result_t r;
		int i, p;
		r = '0;
		case (c.cmd)
			csi_pkg::CMD_ADD: begin
				if (model_count >= csi_pkg::MAX_POINTS) begin
					r.status = csi_pkg::ST_FULL;
				end else begin
					for (i = 0; i < model_count; i++)
						if (model_values[i] > $signed(c.value))
							break;
					for (int j = model_count; j > i; j--) begin
						model_values[j] = model_values[j-1];
						model_colours[j] = model_colours[j-1];
					end
					model_values[i] = c.value;
					model_colours[i] = c.rgba;
					model_count++;
					r.placed_at = 4'(i);
				end
			end
			csi_pkg::CMD_SET: begin
				p = int'(c.position);
				if (p >= model_count) begin
					r.status = csi_pkg::ST_BAD_POS;
				end else begin
					if (c.write_colour)
						model_colours[p] = c.rgba;
					if (c.write_value) begin
						model_values[p] = c.value;
						while (p > 0 && model_values[p-1] > model_values[p]) begin
							swap_points(p - 1, p);
							p--;
						end
						while (p + 1 < model_count && model_values[p+1] < model_values[p]) begin
							swap_points(p, p + 1);
							p++;
						end
					end
					r.placed_at = 4'(p);
				end
			end
			csi_pkg::CMD_REMOVE: begin
				p = int'(c.position);
				if (p >= model_count) begin
					r.status = csi_pkg::ST_BAD_POS;
				end else begin
					for (int j = p; j + 1 < model_count; j++) begin
						model_values[j] = model_values[j+1];
						model_colours[j] = model_colours[j+1];
					end
					model_count--;
				end
			end
			csi_pkg::CMD_LOOKUP: r.rgba = lookup_colour(c.value);
			csi_pkg::CMD_CLEAR: model_count = 0;
			default: ;
		endcase
		r.point_count = 5'(model_count);
		return r;
	endfunction

	function automatic void compare_result(result_t want, result_t got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result mismatch: want rgba=%h st=%0d at=%0d n=%0d, %s",
					want.rgba, want.status, want.placed_at, want.point_count,
					$sformatf("got rgba=%h st=%0d at=%0d n=%0d",
						got.rgba, got.status, got.placed_at, got.point_count));
		end
	endfunction

	// result receiver with random stalls and one long hold
	initial begin
		int gap;
		result_t got;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = unpack_result(m_tdata);
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word %h", m_tdata);
				end else begin
					compare_result(pending_results.pop_front(), got);
				end
			end
			if (hold_receiver) begin
				m_tready <= 1'b0;
			end else if (m_tready && $urandom_range(0, 3) == 0) begin
				gap = ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 60)) :
					int'($urandom_range(1, 3));
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// sends one command word, stored results are predicted on acceptance
	task automatic send_command(command_t c, bit typed, result_t want);
		result_t predicted;
		s_tdata  <= pack_command(c);
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predicted = apply_command(c);
		if (typed && predicted != want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("table model disagrees with typed row for cmd %0d", c.cmd);
		end
		pending_results.push_back(typed ? want : predicted);
		if ($urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat (($urandom_range(0, 12) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 2))
				@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_interpolate(bit v);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		model_interp = v;
	endtask

	function automatic command_t make_op(logic [2:0] cmd, logic [31:0] value,
			logic [31:0] rgba, logic [3:0] position, bit wv, bit wc);
		command_t c;
		c.cmd = cmd;
		c.value = value;
		c.rgba = rgba;
		c.position = position;
		c.write_value = wv;
		c.write_colour = wc;
		return c;
	endfunction

	function automatic result_t make_result(logic [31:0] rgba, logic [1:0] st,
			logic [3:0] at, logic [4:0] n);
		result_t r;
		r.rgba = rgba;
		r.status = st;
		r.placed_at = at;
		r.point_count = n;
		return r;
	endfunction

	// random command: mostly well-formed edits and lookups inside the range
	function automatic command_t random_command();
		command_t c;
		int pick;
		pick = int'($urandom_range(0, 99));
		c.rgba = $urandom;
		c.write_value = 1'($urandom_range(0, 1));
		c.write_colour = 1'($urandom_range(0, 1));
		c.position = (model_count > 0 && $urandom_range(0, 5) != 0) ?
			4'($urandom_range(0, model_count - 1)) : 4'($urandom_range(0, 15));
		if ($urandom_range(0, 3) == 0)
			c.value = $urandom;
		else if ($urandom_range(0, 5) == 0 && model_count > 0)
			c.value = model_values[$urandom_range(0, model_count - 1)];
		else
			c.value = $signed($urandom_range(0, 2000)) - 1000;
		if (pick < 30)
			c.cmd = csi_pkg::CMD_ADD;
		else if (pick < 45)
			c.cmd = csi_pkg::CMD_SET;
		else if (pick < 55)
			c.cmd = csi_pkg::CMD_REMOVE;
		else if (pick < 95)
			c.cmd = csi_pkg::CMD_LOOKUP;
		else if (pick < 97)
			c.cmd = csi_pkg::CMD_CLEAR;
		else
			c.cmd = 3'($urandom_range(5, 7));
		return c;
	endfunction

	// stimulus
	initial begin
		directed_row_t rows[$];
		result_t none;
		command_t c;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		mismatches = 0;
		model_count = 0;
		model_interp = 1'b1;
		hold_receiver = 1'b0;
		none = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows: empty table, errors, extremes, ties, moves, blends
		rows.push_back('{make_op(csi_pkg::CMD_LOOKUP, 32'h0, 32'h0, 4'd0, 1'b0, 1'b0), 1'b1,
			make_result(csi_pkg::EMPTY_COLOUR, csi_pkg::ST_OK, 4'd0, 5'd0)});
		rows.push_back('{make_op(csi_pkg::CMD_SET, 32'h0, 32'hFFFFFFFF, 4'd0, 1'b1, 1'b1),
			1'b1, make_result(32'h0, csi_pkg::ST_BAD_POS, 4'd0, 5'd0)});
		rows.push_back('{make_op(csi_pkg::CMD_REMOVE, 32'h0, 32'h0, 4'd15, 1'b0, 1'b0), 1'b1,
			make_result(32'h0, csi_pkg::ST_BAD_POS, 4'd0, 5'd0)});
		rows.push_back('{make_op(csi_pkg::CMD_ADD, 32'h80000000, 32'h000000FF, 4'd0, 1'b0,
			1'b0), 1'b1, make_result(32'h0, csi_pkg::ST_OK, 4'd0, 5'd1)});
		rows.push_back('{make_op(csi_pkg::CMD_ADD, 32'h7FFFFFFF, 32'hFFFFFF00, 4'd0, 1'b0,
			1'b0), 1'b1, make_result(32'h0, csi_pkg::ST_OK, 4'd1, 5'd2)});
		rows.push_back('{make_op(csi_pkg::CMD_LOOKUP, 32'h0, 32'h0, 4'd0, 1'b0, 1'b0), 1'b0,
			none});
		rows.push_back('{make_op(csi_pkg::CMD_LOOKUP, 32'h7FFFFFFF, 32'h0, 4'd0, 1'b0, 1'b0),
			1'b1, make_result(32'hFFFFFF00, csi_pkg::ST_OK, 4'd0, 5'd2)});
		rows.push_back('{make_op(csi_pkg::CMD_ADD, 32'h00010000, 32'h10203040, 4'd0, 1'b0,
			1'b0), 1'b0, none});
		rows.push_back('{make_op(csi_pkg::CMD_ADD, 32'h00010000, 32'h50607080, 4'd0, 1'b0,
			1'b0), 1'b0, none});
		rows.push_back('{make_op(csi_pkg::CMD_LOOKUP, 32'h00010000, 32'h0, 4'd0, 1'b0, 1'b0),
			1'b0, none});
		rows.push_back('{make_op(csi_pkg::CMD_LOOKUP, 32'h00008000, 32'h0, 4'd0, 1'b0, 1'b0),
			1'b0, none});
		rows.push_back('{make_op(csi_pkg::CMD_SET, 32'h80000000, 32'h0, 4'd3, 1'b1, 1'b0),
			1'b0, none});
		rows.push_back('{make_op(csi_pkg::CMD_SET, 32'h7FFFFFFF, 32'hAABBCCDD, 4'd0, 1'b1,
			1'b1), 1'b0, none});
		rows.push_back('{make_op(csi_pkg::CMD_SET, 32'h0, 32'h01020304, 4'd2, 1'b0, 1'b1),
			1'b0, none});
		rows.push_back('{make_op(csi_pkg::CMD_LOOKUP, 32'h80000000, 32'h0, 4'd0, 1'b0, 1'b0),
			1'b0, none});
		rows.push_back('{make_op(csi_pkg::CMD_REMOVE, 32'h0, 32'h0, 4'd0, 1'b0, 1'b0), 1'b0,
			none});
		rows.push_back('{make_op(3'd5, 32'hFFFFFFFF, 32'hFFFFFFFF, 4'd15, 1'b1, 1'b1), 1'b0,
			none});
		rows.push_back('{make_op(3'd7, 32'h0, 32'h0, 4'd0, 1'b0, 1'b0), 1'b0, none});
		rows.push_back('{make_op(csi_pkg::CMD_CLEAR, 32'h0, 32'h0, 4'd0, 1'b0, 1'b0), 1'b1,
			make_result(32'h0, csi_pkg::ST_OK, 4'd0, 5'd0)});
		foreach (rows[i])
			send_command(rows[i].op, rows[i].typed, rows[i].want);

		// fill the table, overflow it, then check with blending off
		for (int i = 0; i < csi_pkg::MAX_POINTS; i++)
			send_command(make_op(csi_pkg::CMD_ADD, i * 32'h00010000, $urandom, 4'd0, 1'b0,
				1'b0), 1'b0, none);
		send_command(make_op(csi_pkg::CMD_ADD, 32'h0, 32'h0, 4'd0, 1'b0, 1'b0), 1'b1,
			make_result(32'h0, csi_pkg::ST_FULL, 4'd0, 5'(csi_pkg::MAX_POINTS)));
		wait_drained();
		write_interpolate(1'b0);
		send_command(make_op(csi_pkg::CMD_LOOKUP, 32'h00018000, 32'h0, 4'd0, 1'b0, 1'b0),
			1'b0, none);
		wait_drained();
		write_interpolate(1'b1);

		// long receiver hold while the sender keeps offering words
		fork
			begin
				hold_receiver = 1'b1;
				repeat (400) @(posedge clk);
				hold_receiver = 1'b0;
			end
			for (int i = 0; i < 20; i++)
				send_command(random_command(), 1'b0, none);
		join

		// random phases with interpolate toggled between them
		for (int phase = 0; phase < 4; phase++) begin
			for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
				c = random_command();
				send_command(c, 1'b0, none);
			end
			wait_drained();
			write_interpolate(phase[0]);
		end

		wait_drained();
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
